FILE: rtl/core/mfb_pkg.sv
// shared types, constants and helpers of the monochrome band fill core
package mfb_pkg;

   // default frame store size in bytes
   localparam int unsigned FRAME_BYTES_DEF = 1024;

   // byte address arithmetic width, covers worst case row base plus span
   localparam int unsigned ADDR_W = 22;

   // field widths
   localparam int unsigned Y_W     = 10;
   localparam int unsigned X_W     = 13;
   localparam int unsigned BW_W    = 10;
   localparam int unsigned PEN_W   = 8;
   localparam int unsigned RADDR_W = 10;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned PITCH_W = 14;
   localparam int unsigned BASE_W  = 10;
   localparam int unsigned STRIDE_W = PITCH_W - 2;

   // csr channel
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_PITCH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = CSR_IDX_W'(1);

   localparam logic [PITCH_W-1:0] PITCH_RST = PITCH_W'(128);
   localparam logic [BASE_W-1:0]  BASE_RST  = BASE_W'(0);

   // item kinds and pen codes
   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [PEN_W-1:0] PEN_CLEAR = PEN_W'(0);
   localparam logic [PEN_W-1:0] PEN_SET   = PEN_W'(1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_CAPTURE,
      ST_SETUP,
      ST_ROW,
      ST_BYTE,
      ST_MODIFY,
      ST_DONE
   } state_type;

   // store port controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // pixels of the span that land in the current byte
   function automatic logic [3:0] span_count(input logic [2:0] bit_pos,
                                             input logic [BW_W-1:0] left);
      logic [3:0] room;
      room = 4'd8 - {1'b0, bit_pos};
      if (left < BW_W'(room)) begin
         span_count = left[3:0];
      end else begin
         span_count = room;
      end
   endfunction

   // msb-first mask of the span inside the current byte
   function automatic logic [DATA_W-1:0] span_mask(input logic [2:0] bit_pos,
                                                   input logic [3:0] count);
      logic [3:0] stop;
      stop = {1'b0, bit_pos} + count;
      span_mask = (8'hFF >> bit_pos) & ~(8'hFF >> stop);
   endfunction

endpackage

FILE: rtl/core/mfb_channels.sv
// valid/ready channel interfaces of the band fill core
interface mfb_req_if;
   import mfb_pkg::*;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [Y_W-1:0]     y_start;
   logic [Y_W-1:0]     y_end;
   logic [X_W-1:0]     x_pos;
   logic [BW_W-1:0]    band_width;
   logic [PEN_W-1:0]   pen;
   logic [RADDR_W-1:0] read_address;

   modport source (output valid, cmd, y_start, y_end, x_pos, band_width, pen,
                   read_address, input ready);
   modport sink (input valid, cmd, y_start, y_end, x_pos, band_width, pen,
                 read_address, output ready);
endinterface

interface mfb_rsp_if;
   import mfb_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              clipped;

   modport source (output valid, read_data, clipped, input ready);
   modport sink (input valid, read_data, clipped, output ready);
endinterface

interface mfb_csr_if;
   import mfb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

FILE: rtl/core/mfb_store.sv
// single-port frame store, registered read
module mfb_store #(
   parameter int unsigned DEPTH = mfb_pkg::FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  mfb_pkg::mem_ctl_type          ctl,
   input  logic [$clog2(DEPTH)-1:0]      addr,
   input  logic [mfb_pkg::DATA_W-1:0]    wdata,
   output logic [mfb_pkg::DATA_W-1:0]    rdata
);
   import mfb_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/mono_framebuffer_vline_fill_core.sv
// top level of the monochrome band fill core with its frame store
// steps: read items go fetch, capture, done; draw items go setup, then per row
//   a row step, per byte a read and a write-back or a clip; skipped items: done
// throughput: one item at a time, bound by the single store port doing a read
//   and then a write for every byte the band touches
// reset: control and csr registers reset, then a sweep over every store address
//   zeroes the store; no request transfer until it ends, csr writes taken always
module mono_framebuffer_vline_fill_core #(
   parameter int unsigned FRAME_BYTES = mfb_pkg::FRAME_BYTES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   mfb_req_if.sink  req_bus,
   mfb_rsp_if.source rsp_bus,
   mfb_csr_if.sink  csr_bus
);
   import mfb_pkg::*;

   localparam int unsigned AW = $clog2(FRAME_BYTES);
   localparam logic [ADDR_W-1:0] FRAME_LIMIT = ADDR_W'(FRAME_BYTES);
   localparam logic [AW-1:0]     CLR_LAST    = AW'(FRAME_BYTES - 1);

   // control state
   state_type state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff;
   logic [PITCH_W-1:0] pitch_ff;
   logic [BASE_W-1:0] base_ff;
   logic rsp_valid_ff;

   // item fields held for the whole item
   logic [Y_W-1:0]     y_start_ff;
   logic [Y_W-1:0]     y_end_ff;
   logic [X_W-1:0]     x_pos_ff;
   logic [BW_W-1:0]    width_ff;
   logic [PEN_W-1:0]   pen_ff;
   logic [RADDR_W-1:0] raddr_ff;

   // walk over rows and bytes
   logic [Y_W-1:0]    row_ff;
   logic [ADDR_W-1:0] row_base_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [2:0]        bit_ff;
   logic [BW_W-1:0]   left_ff;

   // result being built and result register
   logic [DATA_W-1:0] data_ff;
   logic              clip_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_clip_ff;

   // store port
   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     mem_addr;
   logic [DATA_W-1:0] mem_wdata;
   logic [DATA_W-1:0] mem_rdata;

   // combinational helpers
   logic [PITCH_W:0]    stride_sum;
   logic [STRIDE_W-1:0] stride;
   logic [3:0]          span_n;
   logic [DATA_W-1:0]   span_m;
   logic [BW_W-1:0]     left_next;
   logic                row_last;
   logic                addr_ok;
   logic                req_go;
   logic                req_raddr_ok;
   logic                req_draw_ok;
   logic                step_byte;
   logic                rsp_load;
   logic [ADDR_W-1:0]   raddr_ext;

   // stride in bytes, pitch rounded up to whole bytes
   assign stride_sum = {1'b0, pitch_ff} + (PITCH_W + 1)'(7);
   assign stride     = stride_sum[PITCH_W:3];

   assign span_n    = span_count(bit_ff, left_ff);
   assign span_m    = span_mask(bit_ff, span_n);
   assign left_next = left_ff - BW_W'(span_n);
   assign row_last  = (row_ff == y_end_ff);
   assign addr_ok   = (addr_ff < FRAME_LIMIT);
   assign raddr_ext = ADDR_W'(raddr_ff);

   assign req_go       = req_bus.valid && req_bus.ready;
   assign req_raddr_ok = (ADDR_W'(req_bus.read_address) < FRAME_LIMIT);
   // inert pen, empty band or reversed rows draw nothing
   assign req_draw_ok  = ((req_bus.pen == PEN_CLEAR) || (req_bus.pen == PEN_SET))
                         && (req_bus.band_width != '0)
                         && (req_bus.y_end >= req_bus.y_start);

   // a byte is finished: clipped without access, or written back
   assign step_byte = ((state_ff == ST_BYTE) && !addr_ok) || (state_ff == ST_MODIFY);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_go) begin
               if (req_bus.cmd == CMD_READ) begin
                  state_in = req_raddr_ok ? ST_FETCH : ST_DONE;
               end else begin
                  state_in = req_draw_ok ? ST_SETUP : ST_DONE;
               end
            end
         end
         ST_FETCH:   state_in = ST_CAPTURE;
         ST_CAPTURE: state_in = ST_DONE;
         ST_SETUP:   state_in = ST_ROW;
         ST_ROW:     state_in = ST_BYTE;
         ST_BYTE, ST_MODIFY: begin
            if ((state_ff == ST_BYTE) && addr_ok) begin
               state_in = ST_MODIFY;
            end else if (left_next != '0) begin
               state_in = ST_BYTE;
            end else begin
               state_in = row_last ? ST_DONE : ST_ROW;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: handshake and store port
   always_comb begin
      req_bus.ready = 1'b0;
      mem_ctl       = '0;
      mem_addr      = addr_ff[AW-1:0];
      mem_wdata     = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = clr_cnt_ff;
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_FETCH: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = raddr_ext[AW-1:0];
         end
         ST_BYTE: begin
            // bytes beyond the store are never read
            mem_ctl.rd_en = addr_ok;
         end
         ST_MODIFY: begin
            mem_ctl.wr_en = 1'b1;
            if (pen_ff == PEN_CLEAR) begin
               mem_wdata = mem_rdata & ~span_m;
            end else begin
               mem_wdata = mem_rdata | span_m;
            end
         end
         ST_CAPTURE, ST_SETUP, ST_ROW, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   mfb_store #(
      .DEPTH (FRAME_BYTES)
   ) u_store (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // configuration registers, the sender changes them only between items; the core does not enforce it
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= PITCH_RST;
         base_ff  <= BASE_RST;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.addr)
            CSR_PITCH: pitch_ff <= csr_bus.wdata[PITCH_W-1:0];
            CSR_BASE:  base_ff  <= csr_bus.wdata[BASE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_go) begin
         y_start_ff <= req_bus.y_start;
         y_end_ff   <= req_bus.y_end;
         x_pos_ff   <= req_bus.x_pos;
         width_ff   <= req_bus.band_width;
         pen_ff     <= req_bus.pen;
         raddr_ff   <= req_bus.read_address;
         data_ff    <= '0;
         clip_ff    <= 1'b0;
      end
      if (state_ff == ST_CAPTURE) begin
         data_ff <= mem_rdata;
      end
      if (state_ff == ST_SETUP) begin
         // first row start: base + y_start * stride
         row_ff      <= y_start_ff;
         row_base_ff <= ADDR_W'(base_ff) + ADDR_W'(y_start_ff) * ADDR_W'(stride);
      end
      if (state_ff == ST_ROW) begin
         addr_ff <= row_base_ff + ADDR_W'(x_pos_ff[X_W-1:3]);
         bit_ff  <= x_pos_ff[2:0];
         left_ff <= width_ff;
      end
      if (step_byte) begin
         if (!addr_ok) begin
            clip_ff <= 1'b1;
         end
         left_ff <= left_next;
         bit_ff  <= 3'd0;
         addr_ff <= addr_ff + ADDR_W'(1);
         if ((left_next == '0) && !row_last) begin
            row_ff      <= row_ff + Y_W'(1);
            row_base_ff <= row_base_ff + ADDR_W'(stride);
         end
      end
   end

   // result register, parts the result side from the sequencer
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= data_ff;
         rsp_clip_ff <= clip_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;
   assign rsp_bus.clipped   = rsp_clip_ff;

   // the single store port never reads and writes in one cycle
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("store read and write in one cycle");

   // write-back only lands inside the store
   a_modify_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> (addr_ff < FRAME_LIMIT))
      else $error("write-back beyond store");

   // a byte step always has pixels left to place
   a_byte_has_span: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_BYTE) || (state_ff == ST_MODIFY)) |-> (left_ff != '0))
      else $error("byte step with empty span");

   // the write-back follows the read of the same byte
   a_modify_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> ($past(mem_ctl.rd_en) && $stable(addr_ff)))
      else $error("write-back without matching read");

   // a clipped result never carries read data
   a_clip_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clip_ff) |-> (rsp_data_ff == '0))
      else $error("clipped result with read data");

endmodule
